>>> rtl/array_linked_list_with_free_list_defines.svh
// Assertion macros for the linked list block.
// Expects clk and rst in the scope where a macro is used.
`ifndef ARRAY_LINKED_LIST_WITH_FREE_LIST_DEFINES_SVH
`define ARRAY_LINKED_LIST_WITH_FREE_LIST_DEFINES_SVH

// Condition that holds at every edge out of reset
`define ALFL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define ALFL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ALFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/alfl_pkg.sv
// Shared types and constants of the linked list block.
// No dependencies.
package alfl_pkg;

  localparam int NODE_COUNT_DEF = 8;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_VACANT    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_POP,
    S_INS_WALK,
    S_DEL_WALK,
    S_DEL_FREE,
    S_EMIT
  } state_t;

endpackage

>>> rtl/alfl_ifs.sv
// Valid/ready channels of the linked list block: request and response.
// No dependencies.
interface alfl_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] element;
  logic [3:0] index;

  modport source (output valid, mode, element, index, input ready);
  modport sink (input valid, mode, element, index, output ready);
endinterface

interface alfl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] slot;

  modport source (output valid, status, slot, input ready);
  modport sink (input valid, status, slot, output ready);
endinterface

>>> rtl/alfl_link_store.sv
// Link store: one write port, one registered read port.
// Per-entry written bits make an unwritten entry read as its index plus one.
module alfl_link_store #(
  parameter int NODE_COUNT = alfl_pkg::NODE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [$clog2(NODE_COUNT)-1:0]   waddr,
  input  logic [$clog2(NODE_COUNT+1)-1:0] wdata,
  input  logic [$clog2(NODE_COUNT)-1:0]   raddr,
  output logic [$clog2(NODE_COUNT+1)-1:0] rdata
);

  localparam int LW = $clog2(NODE_COUNT + 1);

  logic [LW-1:0]         mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] written;

  // Track which entries hold a stored link
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, reset chain for unwritten entries
  always_ff @(posedge clk) begin
    if (written[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= LW'(raddr) + LW'(1);
    end
  end

endmodule

>>> rtl/alfl_value_store.sv
// Node byte store: one write port, one registered read port with enable.
// Contents are undefined until written.
module alfl_value_store #(
  parameter int NODE_COUNT = alfl_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(NODE_COUNT)-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic                          re,
  input  logic [$clog2(NODE_COUNT)-1:0] raddr,
  output logic [7:0]                    rdata
);

  logic [7:0] mem [NODE_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/alfl_ctrl.sv
// Sequencer of the linked list block: list and free-list heads, link walks,
// result register. Uses alfl_pkg, the channel interfaces and the defines header; drives both stores.
`include "array_linked_list_with_free_list_defines.svh"

module alfl_ctrl #(
  parameter int NODE_COUNT = alfl_pkg::NODE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  alfl_in_if.sink                         req,
  alfl_out_if.source                      rsp,
  output logic                            lk_we,
  output logic [$clog2(NODE_COUNT)-1:0]   lk_waddr,
  output logic [$clog2(NODE_COUNT+1)-1:0] lk_wdata,
  output logic [$clog2(NODE_COUNT)-1:0]   lk_raddr,
  input  logic [$clog2(NODE_COUNT+1)-1:0] lk_rdata,
  output logic                            val_we,
  output logic [$clog2(NODE_COUNT)-1:0]   val_waddr,
  output logic [7:0]                      val_wdata,
  output logic                            val_re,
  output logic [$clog2(NODE_COUNT)-1:0]   val_raddr,
  input  logic [7:0]                      val_rdata
);

  import alfl_pkg::*;

  localparam int LW = $clog2(NODE_COUNT + 1);
  localparam int AW = $clog2(NODE_COUNT);
  localparam int CW = (LW > 4) ? LW : 4;
  localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

  state_t        state, state_next;
  logic [LW-1:0] free_head, free_head_next;
  logic [LW-1:0] list_head, list_head_next;
  logic [LW-1:0] cur, cur_next;
  logic [LW-1:0] prev, prev_next;
  logic [LW-1:0] steps, steps_next;
  logic [LW-1:0] alloc, alloc_next;
  logic [AW-1:0] idx, idx_next;
  status_t       res_status, res_status_next;
  logic [2:0]    res_slot, res_slot_next;
  logic          out_valid;
  status_t       out_status;
  logic [2:0]    out_slot;
  logic          emit;
  logic          walk_more;

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.slot   = out_slot;

  // Continue the delete walk while in bounds and not at the target
  assign walk_more = (steps < NIL) && (cur != NIL) && (cur != LW'(idx));

  // State and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      list_head <= NIL;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      list_head <= list_head_next;
    end
  end

  // Walk and result working registers
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    prev       <= prev_next;
    steps      <= steps_next;
    alloc      <= alloc_next;
    idx        <= idx_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
  end

  // Next state and store controls
  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    list_head_next  = list_head;
    cur_next        = cur;
    prev_next       = prev;
    steps_next      = steps;
    alloc_next      = alloc;
    idx_next        = idx;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    lk_we           = 1'b0;
    lk_waddr        = cur[AW-1:0];
    lk_wdata        = alloc;
    lk_raddr        = cur[AW-1:0];
    val_we          = 1'b0;
    val_waddr       = free_head[AW-1:0];
    val_wdata       = req.element;
    val_re          = 1'b0;
    val_raddr       = AW'(req.index);
    emit            = 1'b0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.mode == MODE_INSERT) begin
            if (free_head == NIL) begin
              res_status_next = ST_FULL;
              res_slot_next   = 3'd0;
              state_next      = S_EMIT;
            end else begin
              // Store the byte, fetch the free-list successor
              val_we     = 1'b1;
              lk_raddr   = free_head[AW-1:0];
              alloc_next = free_head;
              state_next = S_INS_POP;
            end
          end else begin
            if (list_head == NIL) begin
              res_status_next = ST_EMPTY;
              res_slot_next   = 3'd0;
              state_next      = S_EMIT;
            end else if (CW'(req.index) >= CW'(NODE_COUNT)) begin
              res_status_next = ST_BAD_INDEX;
              res_slot_next   = 3'd0;
              state_next      = S_EMIT;
            end else begin
              // Start at the head, fetch the target byte
              val_re     = 1'b1;
              idx_next   = AW'(req.index);
              cur_next   = list_head;
              prev_next  = NIL;
              steps_next = '0;
              lk_raddr   = list_head[AW-1:0];
              state_next = S_DEL_WALK;
            end
          end
        end
      end

      S_INS_POP: begin
        // Pop the free list and terminate the new node
        free_head_next = lk_rdata;
        lk_we          = 1'b1;
        lk_waddr       = alloc[AW-1:0];
        lk_wdata       = NIL;
        if (list_head == NIL) begin
          list_head_next  = alloc;
          res_status_next = ST_OK;
          res_slot_next   = 3'(alloc);
          state_next      = S_EMIT;
        end else begin
          cur_next   = list_head;
          steps_next = '0;
          lk_raddr   = list_head[AW-1:0];
          state_next = S_INS_WALK;
        end
      end

      S_INS_WALK: begin
        // Advance to the tail, then link the new node behind it
        if ((steps < NIL) && (lk_rdata < NIL)) begin
          cur_next   = lk_rdata;
          steps_next = steps + LW'(1);
          lk_raddr   = lk_rdata[AW-1:0];
        end else begin
          lk_we           = 1'b1;
          lk_waddr        = cur[AW-1:0];
          lk_wdata        = alloc;
          res_status_next = ST_OK;
          res_slot_next   = 3'(alloc);
          state_next      = S_EMIT;
        end
      end

      S_DEL_WALK: begin
        if (walk_more) begin
          prev_next  = cur;
          cur_next   = lk_rdata;
          steps_next = steps + LW'(1);
          lk_raddr   = lk_rdata[AW-1:0];
        end else if ((cur != LW'(idx)) || (val_rdata == 8'd0)) begin
          res_status_next = ST_VACANT;
          res_slot_next   = 3'd0;
          state_next      = S_EMIT;
        end else begin
          // Unlink the target: its link replaces the predecessor's
          if (prev == NIL) begin
            list_head_next = lk_rdata;
          end else begin
            lk_we    = 1'b1;
            lk_waddr = prev[AW-1:0];
            lk_wdata = lk_rdata;
          end
          state_next = S_DEL_FREE;
        end
      end

      S_DEL_FREE: begin
        // Push the freed node on the free list
        lk_we           = 1'b1;
        lk_waddr        = idx;
        lk_wdata        = free_head;
        free_head_next  = LW'(idx);
        res_status_next = ST_OK;
        res_slot_next   = 3'(idx);
        state_next      = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= res_status;
      out_slot   <= res_slot;
    end
  end

  `ALFL_ASSERT_ALWAYS(a_free_head_range, free_head <= NIL, "free head beyond null")
  `ALFL_ASSERT_IMPL(a_pool_not_lost, state == S_IDLE && list_head == NIL, free_head != NIL, "list and free list both empty")
  `ALFL_ASSERT_IMPL(a_slot_zero_on_error, rsp.valid && rsp.status != ST_OK, rsp.slot == 3'd0, "slot not zero on error")
  `ALFL_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready right after accept")
  `ALFL_ASSERT_IMPL(a_walk_bound, state == S_INS_WALK || state == S_DEL_WALK, steps <= NIL, "walk ran past pool size")

endmodule

>>> rtl/array_linked_list_with_free_list.sv
// Linked list over a node pool with a free list. An insert pops the free list and walks
// to the tail, a delete walks to its target and frees it, a rejected request skips both;
// the walk follows one link per cycle through the single read port of the link store.
// One word in flight; the next request is taken the cycle after its answer enters the
// output register; an output stall delays that.
// Synchronous reset: empty list, all nodes free, no clearing.
module array_linked_list_with_free_list #(
  parameter int NODE_COUNT = alfl_pkg::NODE_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  alfl_in_if.sink    req,
  alfl_out_if.source rsp
);

  localparam int LW = $clog2(NODE_COUNT + 1);
  localparam int AW = $clog2(NODE_COUNT);

  logic          lk_we;
  logic [AW-1:0] lk_waddr;
  logic [LW-1:0] lk_wdata;
  logic [AW-1:0] lk_raddr;
  logic [LW-1:0] lk_rdata;
  logic          val_we;
  logic [AW-1:0] val_waddr;
  logic [7:0]    val_wdata;
  logic          val_re;
  logic [AW-1:0] val_raddr;
  logic [7:0]    val_rdata;

  alfl_ctrl #(.NODE_COUNT(NODE_COUNT)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .lk_we     (lk_we),
    .lk_waddr  (lk_waddr),
    .lk_wdata  (lk_wdata),
    .lk_raddr  (lk_raddr),
    .lk_rdata  (lk_rdata),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .val_re    (val_re),
    .val_raddr (val_raddr),
    .val_rdata (val_rdata)
  );

  alfl_link_store #(.NODE_COUNT(NODE_COUNT)) u_link_store (
    .clk   (clk),
    .rst   (rst),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  alfl_value_store #(.NODE_COUNT(NODE_COUNT)) u_value_store (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .re    (val_re),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

endmodule
